// ===== rtl/msbd_pkg.sv =====
package msbd_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  localparam logic [7:0]  EMPTY_DEPTH = 8'd127;
  localparam logic [31:0] CLEAR_RESET = 32'd66666;

  // Item opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Depth test modes
  localparam logic [1:0] MODE_ALWAYS  = 2'd0;
  localparam logic [1:0] MODE_EMPTY   = 2'd1;
  localparam logic [1:0] MODE_COMPARE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BLEND_MODE   = 1'b0;
  localparam logic CFG_CLEAR_COLOUR = 1'b1;

  typedef struct packed {
    logic capture;   // latch the item and read the stores
    logic wr_draw;   // write the blended spot back
    logic clr_en;    // write one entry of the clear sweep
    logic load_out;  // move the result into the output register
  } msbd_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic clr_last;   // clear sweep sits on its last entry
    logic draw_pass;  // latched item is a draw that passes its test
  } msbd_stat_t;

endpackage

// ===== rtl/msbd_ctrl.sv =====
module msbd_ctrl import msbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  msbd_stat_t stat,
  output msbd_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_CLEAR  = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.wr_draw  = 1'b0;
    cmd.clr_en   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_op == OP_CLEAR) ? ST_CLEAR : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.wr_draw = stat.draw_pass;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/msbd_dpath.sv =====
module msbd_dpath import msbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  msbd_cmd_t          cmd,
  output msbd_stat_t         stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_sprite_x,
  input  logic [5:0]         in_sprite_y,
  input  logic [6:0]         in_sprite_width,
  input  logic signed [7:0]  in_sprite_depth,
  input  logic               in_flip,
  input  logic [5:0]         in_pixel_col,
  input  logic [5:0]         in_pixel_row,
  input  logic [31:0]        in_src_pixel,
  input  logic [7:0]         in_mask_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_pixel_colour,
  output logic signed [7:0]  out_pixel_depth,
  output logic               out_wrote
);

  logic [31:0] colour_mem [STORE_SIZE];
  logic [7:0]  depth_mem  [STORE_SIZE];

  logic [1:0]        blend_mode_r;
  logic [31:0]       clear_colour_r;
  logic [ADDR_W-1:0] clear_index_r;

  logic [1:0]        op_r;
  logic              ok_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        dep_r;
  logic [31:0]       src_r;
  logic [7:0]        mask_r;
  logic [31:0]       rcol_r;
  logic [7:0]        rdep_r;

  logic              out_valid_r;
  logic [31:0]       out_colour_r;
  logic [7:0]        out_depth_r;
  logic              out_wrote_r;

  logic [7:0]        spot_x;
  logic [7:0]        spot_y;
  logic              in_sprite;
  logic              on_screen;
  logic              spot_ok;
  logic [ADDR_W-1:0] spot_addr;
  logic              pass;
  logic [31:0]       cmask;
  logic [31:0]       new_colour;
  logic [7:0]        new_depth;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wcolour;
  logic [7:0]        wdepth;
  logic              is_read;
  logic              out_take;

  // Screen spot of the incoming item
  always_comb begin
    is_read   = (in_op == OP_READ);
    in_sprite = ({1'b0, in_pixel_col} < in_sprite_width);
    if (is_read) begin
      spot_x = 8'(in_sprite_x);
      spot_y = 8'(in_sprite_y);
    end else if (in_flip) begin
      spot_x = 8'(in_sprite_x) + 8'(in_sprite_width) - 8'd1 - 8'(in_pixel_col);
      spot_y = 8'(in_sprite_y) + 8'(in_pixel_row);
    end else begin
      spot_x = 8'(in_sprite_x) + 8'(in_pixel_col);
      spot_y = 8'(in_sprite_y) + 8'(in_pixel_row);
    end
    on_screen = (32'(spot_x) < SCREEN_WIDTH) && (32'(spot_y) < SCREEN_HEIGHT);
    spot_ok   = on_screen && (is_read || in_sprite);
    spot_addr = ADDR_W'(32'(spot_y) * SCREEN_WIDTH + 32'(spot_x));
  end

  // Depth test and blend on the stored word
  always_comb begin
    case (blend_mode_r)
      MODE_EMPTY:   pass = (rdep_r == EMPTY_DEPTH);
      MODE_COMPARE: pass = ($signed(dep_r) < $signed(rdep_r));
      default:      pass = 1'b1;
    endcase
    cmask      = {{24{mask_r[7]}}, mask_r};
    new_colour = (rcol_r & cmask) | src_r;
    new_depth  = (rdep_r & mask_r) | dep_r;
  end

  assign stat.draw_pass = (op_r == OP_DRAW) && ok_r && pass;
  assign stat.clr_last  = (32'(clear_index_r) == STORE_SIZE - 1);
  assign out_take       = out_valid_r && !out_stall;
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    we = cmd.clr_en || cmd.wr_draw;
    if (cmd.clr_en) begin
      waddr   = clear_index_r;
      wcolour = clear_colour_r;
      wdepth  = EMPTY_DEPTH;
    end else begin
      waddr   = addr_r;
      wcolour = new_colour;
      wdepth  = new_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      colour_mem[waddr] <= wcolour;
      depth_mem[waddr]  <= wdepth;
    end
    if (cmd.capture) begin
      rcol_r <= colour_mem[spot_addr];
      rdep_r <= depth_mem[spot_addr];
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok_r   <= spot_ok;
      addr_r <= spot_addr;
      dep_r  <= in_sprite_depth;
      src_r  <= in_src_pixel;
      mask_r <= in_mask_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_CLEAR;
    end else if (cmd.capture) begin
      op_r <= in_op;
    end
  end

  // Configuration and clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r   <= MODE_ALWAYS;
      clear_colour_r <= CLEAR_RESET;
      clear_index_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_BLEND_MODE) begin
        blend_mode_r <= cfg_wdata[1:0];
      end
      if (cfg_we && cfg_index == CFG_CLEAR_COLOUR) begin
        clear_colour_r <= cfg_wdata;
      end
      if (cmd.clr_en) begin
        clear_index_r <= stat.clr_last ? '0 : clear_index_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_colour_r <= (op_r == OP_READ && ok_r) ? rcol_r : 32'd0;
      out_depth_r  <= (op_r == OP_READ && ok_r) ? rdep_r : 8'd0;
      out_wrote_r  <= stat.draw_pass;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_colour = out_colour_r;
  assign out_pixel_depth  = out_depth_r;
  assign out_wrote        = out_wrote_r;

endmodule

// ===== rtl/masked_sprite_blit_depth.sv =====
// Masked sprite blitter with a colour frame store and a signed depth store.
// Input channel (in_*): one beat per item, taken when in_valid is high and
// in_stall is low. Ops: clear, draw one sprite pixel, read one pixel.
// Result channel (out_*): exactly one beat per item, in item order, taken
// when out_valid is high and out_stall is low.
// Config port (cfg_*): write blend_mode (index 0) or clear_colour (index 1)
// with cfg_we; write only while no item is in flight.
// Draw, read and spare-op items read the store word at the spot when they
// are taken, then test, blend and write back while the input stalls. Their
// result moves into the output register in that write-back step if it is
// free, else from the emit state. The single-port store read-modify-write
// sets these steps. A clear sweeps one entry per cycle; its result is loaded
// after the last entry, and the input opens as that result becomes valid.
// Results land in an output register, so a new item is taken while the
// last result still waits; if the receiver stalls, the next result holds
// inside the block and input stalls until the output register frees up.
// Reset clears control state and the config registers; store contents are
// undefined until the first clear.
module masked_sprite_blit_depth import msbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_sprite_x,
  input  logic [5:0]         in_sprite_y,
  input  logic [6:0]         in_sprite_width,
  input  logic signed [7:0]  in_sprite_depth,
  input  logic               in_flip,
  input  logic [5:0]         in_pixel_col,
  input  logic [5:0]         in_pixel_row,
  input  logic [31:0]        in_src_pixel,
  input  logic [7:0]         in_mask_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_pixel_colour,
  output logic signed [7:0]  out_pixel_depth,
  output logic               out_wrote
);

  msbd_cmd_t  cmd;
  msbd_stat_t stat;

  // Sequence each item: capture, access, sweep, emit
  msbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, spot mapping, depth test, blend and the output register
  msbd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_op),
    .in_sprite_x      (in_sprite_x),
    .in_sprite_y      (in_sprite_y),
    .in_sprite_width  (in_sprite_width),
    .in_sprite_depth  (in_sprite_depth),
    .in_flip          (in_flip),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .in_src_pixel     (in_src_pixel),
    .in_mask_byte     (in_mask_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_colour (out_pixel_colour),
    .out_pixel_depth  (out_pixel_depth),
    .out_wrote        (out_wrote)
  );

endmodule
